### hw/rtl/ofp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Occupancy floor projector package
// Shared widths, codes, item types and helper functions.
// ----------------------------------------------------------------------------
package ofp_pkg;

    localparam int MAX_COLS_DEF = 1024;
    localparam int MAX_ROWS_DEF = 1024;
    localparam int FRAC_BITS    = 8;

    localparam int CRD_W       = 24;
    localparam int HALF_W      = 20;
    localparam int SUM_W       = 26;
    localparam int IDX_W       = 13;
    localparam int SIZE_W      = 11;
    localparam int GS_W        = 14;
    localparam int CNT_W       = 21;
    localparam int GREY_W      = 8;
    localparam int RC_W        = 10;
    localparam int CELL_W      = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 24;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [GREY_W-1:0] GREY_UNKNOWN = 8'd205;
    localparam logic [GREY_W-1:0] GREY_FREE    = 8'd254;
    localparam logic [GREY_W-1:0] GREY_OCC     = 8'd0;

    typedef enum logic [CELL_W-1:0] {
        CELL_UNKNOWN = 2'd0,
        CELL_FREE    = 2'd1,
        CELL_OCC     = 2'd2
    } cell_t;

    typedef enum logic [1:0] {
        KIND_PAINT = 2'd0,
        KIND_READ  = 2'd1,
        KIND_CLEAR = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_PAINT = 2'd1,
        OP_READ  = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIGIN_X    = 3'd0,
        CFG_ORIGIN_Y    = 3'd1,
        CFG_BAND_LOW    = 3'd2,
        CFG_BAND_HIGH   = 3'd3,
        CFG_GRID_WIDTH  = 3'd4,
        CFG_GRID_HEIGHT = 3'd5
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SETUP,
        ST_WALK,
        ST_DRAIN,
        ST_READ,
        ST_READ_DATA,
        ST_DONE
    } bk_state_t;

    typedef struct packed {
        logic [1:0]              kind;
        logic signed [CRD_W-1:0] center_x;
        logic signed [CRD_W-1:0] center_y;
        logic signed [CRD_W-1:0] center_z;
        logic [HALF_W-1:0]       half_size;
        logic                    is_occupied;
        logic [RC_W-1:0]         read_col;
        logic [RC_W-1:0]         read_row;
    } in_t;

    typedef struct packed {
        logic [GREY_W-1:0] cell_grey;
        logic [CNT_W-1:0]  free_count;
        logic [CNT_W-1:0]  occupied_count;
    } out_t;

    typedef struct packed {
        logic signed [CRD_W-1:0] x_min;
        logic signed [CRD_W-1:0] y_min;
        logic signed [CRD_W-1:0] band_low;
        logic signed [CRD_W-1:0] band_high;
        logic [GS_W-1:0]         gw;
        logic [GS_W-1:0]         gh;
    } cfg_t;

    typedef struct packed {
        op_t              op;
        logic             occ;
        logic [IDX_W-1:0] x0;
        logic [IDX_W-1:0] x1;
        logic [IDX_W-1:0] y0;
        logic [IDX_W-1:0] y1;
    } cmd_t;

    function automatic logic [GS_W-1:0] clamp_size(logic [SIZE_W-1:0] v, int limit);
        logic [GS_W-1:0] s;
        s = GS_W'(v);
        if (s == '0) begin
            s = GS_W'(1);
        end
        if (s > GS_W'(limit)) begin
            s = GS_W'(limit);
        end
        return s;
    endfunction

    function automatic logic [GREY_W-1:0] grey_of(logic [CELL_W-1:0] c);
        logic [GREY_W-1:0] g;
        case (c)
            CELL_OCC:  g = GREY_OCC;
            CELL_FREE: g = GREY_FREE;
            default:   g = GREY_UNKNOWN;
        endcase
        return g;
    endfunction

endpackage
`default_nettype wire

### hw/rtl/ofp_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ofp_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 1024
) (
    input  wire logic                                     aclk,
    input  wire logic                                     we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                         wr_data,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data <= mem_reg[rd_addr];
    end

endmodule
`default_nettype wire

### hw/rtl/ofp_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Command queue
// Short first-in first-out store of classified commands between the front
// and the back.
// ----------------------------------------------------------------------------
module ofp_queue #(
    parameter int DEPTH = ofp_pkg::QUEUE_DEPTH
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push_valid,
    output logic               push_ready,
    input  wire ofp_pkg::cmd_t push_data,
    output logic               pop_valid,
    input  wire logic          pop_ready,
    output ofp_pkg::cmd_t      pop_data
);
    import ofp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CQ_W  = $clog2(DEPTH + 1);

    cmd_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CQ_W-1:0]  count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CQ_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CQ_W'(DEPTH))
        else $error("command queue count beyond its depth");

    assert property (@(posedge aclk) disable iff (!aresetn)
        do_push && !do_pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("command queue lost a pushed item");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("command queue pointers disagree when empty");

endmodule
`default_nettype wire

### hw/rtl/ofp_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Front end
// Accepts items, applies the height band test, works out the clipped
// footprint or the read cell and pushes one command per item.
// ----------------------------------------------------------------------------
module ofp_front (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire ofp_pkg::cfg_t cfg,
    input  wire logic          init_done,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire ofp_pkg::in_t  s_data,
    output logic               q_valid,
    input  wire logic          q_ready,
    output ofp_pkg::cmd_t      q_data
);
    import ofp_pkg::*;

    logic                    s1_valid_reg, s1_valid_next;
    logic [1:0]              s1_kind_reg, s1_kind_next;
    logic                    s1_occ_reg, s1_occ_next;
    logic                    s1_band_reg, s1_band_next;
    logic signed [SUM_W-1:0] s1_xlo_reg, s1_xlo_next;
    logic signed [SUM_W-1:0] s1_xhi_reg, s1_xhi_next;
    logic signed [SUM_W-1:0] s1_ylo_reg, s1_ylo_next;
    logic signed [SUM_W-1:0] s1_yhi_reg, s1_yhi_next;
    logic [RC_W-1:0]         s1_col_reg, s1_col_next;
    logic [RC_W-1:0]         s1_row_reg, s1_row_next;

    logic                    accept;
    logic signed [SUM_W-1:0] cx, cy, cz, half, ox, oy, lo, hi;
    logic signed [SUM_W-1:0] xs0, xs1, ys0, ys1;
    logic signed [SUM_W-1:0] x0c, x1c, y0c, y1c, lim_x, lim_y;
    logic                    nonempty, read_ok;

    assign s_ready = init_done && (!s1_valid_reg || q_ready);
    assign accept  = s_valid && s_ready;

    always_comb begin
        cx   = SUM_W'($signed(s_data.center_x));
        cy   = SUM_W'($signed(s_data.center_y));
        cz   = SUM_W'($signed(s_data.center_z));
        half = $signed(SUM_W'(s_data.half_size));
        ox   = SUM_W'($signed(cfg.x_min));
        oy   = SUM_W'($signed(cfg.y_min));
        lo   = SUM_W'($signed(cfg.band_low));
        hi   = SUM_W'($signed(cfg.band_high));

        s1_kind_next = s_data.kind;
        s1_occ_next  = s_data.is_occupied;
        s1_band_next = (hi > lo) && !((cz + half) < lo) && !((cz - half) > hi);
        s1_xlo_next  = cx - half - ox;
        s1_xhi_next  = cx + half - ox;
        s1_ylo_next  = cy - half - oy;
        s1_yhi_next  = cy + half - oy;
        s1_col_next  = s_data.read_col;
        s1_row_next  = s_data.read_row;

        if (accept) begin
            s1_valid_next = 1'b1;
        end else if (q_ready) begin
            s1_valid_next = 1'b0;
        end else begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_comb begin
        xs0   = s1_xlo_reg >>> FRAC_BITS;
        xs1   = s1_xhi_reg >>> FRAC_BITS;
        ys0   = s1_ylo_reg >>> FRAC_BITS;
        ys1   = s1_yhi_reg >>> FRAC_BITS;
        lim_x = $signed(SUM_W'(cfg.gw)) - SUM_W'(1);
        lim_y = $signed(SUM_W'(cfg.gh)) - SUM_W'(1);
        x0c   = (xs0 < 0) ? '0 : xs0;
        y0c   = (ys0 < 0) ? '0 : ys0;
        x1c   = (xs1 > lim_x) ? lim_x : xs1;
        y1c   = (ys1 > lim_y) ? lim_y : ys1;

        nonempty = (x0c <= x1c) && (y0c <= y1c);
        read_ok  = (GS_W'(s1_col_reg) < cfg.gw) && (GS_W'(s1_row_reg) < cfg.gh);

        q_data.occ = s1_occ_reg;
        q_data.x0  = x0c[IDX_W-1:0];
        q_data.x1  = x1c[IDX_W-1:0];
        q_data.y0  = y0c[IDX_W-1:0];
        q_data.y1  = y1c[IDX_W-1:0];
        case (s1_kind_reg)
            KIND_PAINT: q_data.op = (s1_band_reg && nonempty) ? OP_PAINT : OP_NONE;
            KIND_READ: begin
                q_data.op = read_ok ? OP_READ : OP_NONE;
                q_data.x0 = IDX_W'(s1_col_reg);
                q_data.y0 = IDX_W'(s1_row_reg);
            end
            KIND_CLEAR: q_data.op = OP_CLEAR;
            default:    q_data.op = OP_NONE;
        endcase
    end

    assign q_valid = s1_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
        if (accept) begin
            s1_kind_reg <= s1_kind_next;
            s1_occ_reg  <= s1_occ_next;
            s1_band_reg <= s1_band_next;
            s1_xlo_reg  <= s1_xlo_next;
            s1_xhi_reg  <= s1_xhi_next;
            s1_ylo_reg  <= s1_ylo_next;
            s1_yhi_reg  <= s1_yhi_next;
            s1_col_reg  <= s1_col_next;
            s1_row_reg  <= s1_row_next;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && !q_ready |=> s1_valid_reg && $stable(s1_xlo_reg) && $stable(s1_kind_reg))
        else $error("front item changed while the queue was full");

    assert property (@(posedge aclk) disable iff (!aresetn)
        !init_done |-> !s_ready)
        else $error("front took an item during the clearing sweep");

    assert property (@(posedge aclk) disable iff (!aresetn)
        q_valid && (q_data.op == OP_PAINT) |-> (q_data.x0 <= q_data.x1) && (q_data.y0 <= q_data.y1))
        else $error("paint command with an empty footprint");

endmodule
`default_nettype wire

### hw/rtl/ofp_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Back end
// Carries out commands on the cell store: footprint walk with
// read-modify-write, cell reads and clearing sweeps. Keeps the counts and
// holds the result register.
// ----------------------------------------------------------------------------
module ofp_back #(
    parameter int MAX_COLS = ofp_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = ofp_pkg::MAX_ROWS_DEF
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          q_valid,
    output logic               q_ready,
    input  wire ofp_pkg::cmd_t q_data,
    output logic               init_done,
    output logic               m_valid,
    input  wire logic          m_ready,
    output ofp_pkg::out_t      m_data
);
    import ofp_pkg::*;

    localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int DEPTH  = MAX_COLS * MAX_ROWS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    bk_state_t         state_reg, state_next;
    cmd_t              cmd_reg, cmd_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [ADDR_W-1:0] base_reg, base_next;
    logic [ADDR_W-1:0] clr_addr_reg, clr_addr_next;
    logic              p_valid_reg, p_valid_next;
    logic [ADDR_W-1:0] p_addr_reg, p_addr_next;
    logic [CNT_W-1:0]  free_reg, free_next;
    logic [CNT_W-1:0]  occ_reg, occ_next;
    logic [GREY_W-1:0] grey_reg, grey_next;
    logic              init_done_reg, init_done_next;
    logic              m_valid_reg, m_valid_next;
    out_t              m_data_reg, m_data_next;

    logic              out_free, clr_last, col_end, walk_last;
    logic [ADDR_W-1:0] walk_addr;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_wr_addr;
    logic [CELL_W-1:0] ram_wr_data, ram_rd_data, new_cell;

    assign out_free  = !m_valid_reg || m_ready;
    assign clr_last  = (clr_addr_reg == ADDR_W'(DEPTH - 1));
    assign col_end   = (col_reg == cmd_reg.x1[COL_W-1:0]);
    assign walk_last = col_end && (row_reg == cmd_reg.y1[ROW_W-1:0]);
    assign walk_addr = base_reg + ADDR_W'(col_reg);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clr_last) begin
                    state_next = init_done_reg ? ST_DONE : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (q_valid) begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: begin
                unique case (cmd_reg.op)
                    OP_PAINT: state_next = ST_WALK;
                    OP_READ:  state_next = ST_READ;
                    OP_CLEAR: state_next = ST_CLEAR;
                    OP_NONE:  state_next = ST_DONE;
                endcase
            end
            ST_WALK: begin
                if (walk_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:     state_next = ST_DONE;
            ST_READ:      state_next = ST_READ_DATA;
            ST_READ_DATA: state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    always_comb begin
        q_ready     = 1'b0;
        ram_we      = p_valid_reg;
        ram_wr_addr = p_addr_reg;
        ram_wr_data = new_cell;
        unique case (state_reg)
            ST_CLEAR: begin
                ram_we      = 1'b1;
                ram_wr_addr = clr_addr_reg;
                ram_wr_data = CELL_UNKNOWN;
            end
            ST_IDLE: q_ready = 1'b1;
            ST_SETUP, ST_WALK, ST_DRAIN, ST_READ, ST_READ_DATA, ST_DONE: begin
            end
        endcase
    end

    always_comb begin
        cmd_next       = cmd_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        base_next      = base_reg;
        clr_addr_next  = clr_addr_reg;
        p_valid_next   = 1'b0;
        p_addr_next    = p_addr_reg;
        free_next      = free_reg;
        occ_next       = occ_reg;
        grey_next      = grey_reg;
        init_done_next = init_done_reg;
        m_data_next    = m_data_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        new_cell       = ram_rd_data;

        if (p_valid_reg) begin
            if (cmd_reg.occ) begin
                new_cell = CELL_OCC;
                if ((ram_rd_data == CELL_FREE) && (free_reg != '0)) begin
                    free_next = free_reg - 1'b1;
                end
                if (ram_rd_data != CELL_OCC) begin
                    occ_next = occ_reg + 1'b1;
                end
            end else if (ram_rd_data == CELL_UNKNOWN) begin
                new_cell  = CELL_FREE;
                free_next = free_reg + 1'b1;
            end
        end

        case (state_reg)
            ST_CLEAR: begin
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_last) begin
                    init_done_next = 1'b1;
                end
            end
            ST_IDLE: begin
                if (q_valid) begin
                    cmd_next = q_data;
                end
            end
            ST_SETUP: begin
                col_next  = cmd_reg.x0[COL_W-1:0];
                row_next  = cmd_reg.y0[ROW_W-1:0];
                base_next = ADDR_W'(cmd_reg.y0[ROW_W-1:0]) * ADDR_W'(MAX_COLS);
                grey_next = GREY_UNKNOWN;
                if (cmd_reg.op == OP_CLEAR) begin
                    clr_addr_next = '0;
                    free_next     = '0;
                    occ_next      = '0;
                end
            end
            ST_WALK: begin
                p_valid_next = 1'b1;
                p_addr_next  = walk_addr;
                if (col_end) begin
                    col_next  = cmd_reg.x0[COL_W-1:0];
                    row_next  = row_reg + 1'b1;
                    base_next = base_reg + ADDR_W'(MAX_COLS);
                end else begin
                    col_next = col_reg + 1'b1;
                end
            end
            ST_READ_DATA: grey_next = grey_of(ram_rd_data);
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next               = 1'b1;
                    m_data_next.cell_grey      = grey_reg;
                    m_data_next.free_count     = free_reg;
                    m_data_next.occupied_count = occ_reg;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            p_valid_reg   <= 1'b0;
            free_reg      <= '0;
            occ_reg       <= '0;
            init_done_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            p_valid_reg   <= p_valid_next;
            free_reg      <= free_next;
            occ_reg       <= occ_next;
            init_done_reg <= init_done_next;
            m_valid_reg   <= m_valid_next;
        end
        cmd_reg    <= cmd_next;
        col_reg    <= col_next;
        row_reg    <= row_next;
        base_reg   <= base_next;
        p_addr_reg <= p_addr_next;
        grey_reg   <= grey_next;
        m_data_reg <= m_data_next;
    end

    ofp_ram #(
        .WIDTH(CELL_W),
        .DEPTH(DEPTH)
    ) u_cell_ram (
        .aclk   (aclk),
        .we     (ram_we),
        .wr_addr(ram_wr_addr),
        .wr_data(ram_wr_data),
        .rd_addr(walk_addr),
        .rd_data(ram_rd_data)
    );

    assign init_done = init_done_reg;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        p_valid_reg |-> $past(state_reg) == ST_WALK)
        else $error("cell write without a preceding walk step");

    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CLEAR |-> !p_valid_reg)
        else $error("clearing sweep overlaps a pending cell write");

    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DONE && out_free |=> m_valid_reg)
        else $error("finished item gave no result");

    assert property (@(posedge aclk) disable iff (!aresetn)
        q_valid && q_ready |=> state_reg == ST_SETUP)
        else $error("popped command not taken into setup");

endmodule
`default_nettype wire

### hw/rtl/occupancy_box_floor_projector.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Occupancy box floor projector
// Projects 3D leaf boxes inside a height band onto a 2D grid of three-state
// cells, keeps free and occupied counts and answers cell reads.
// ----------------------------------------------------------------------------
// A paint item is carried out by the back end walking its clipped footprint one cell per cycle
// through the cell RAM read-modify-write; the back end takes one command at a time, while the
// front and the command queue can take further items meanwhile. A clear item sweeps the cell
// RAM. After reset the same sweep runs and no item is accepted until it ends; configuration
// writes are taken throughout.
module occupancy_box_floor_projector #(
    parameter int MAX_COLS = ofp_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = ofp_pkg::MAX_ROWS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire ofp_pkg::in_t                      s_data,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output ofp_pkg::out_t                          m_data,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [ofp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [ofp_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import ofp_pkg::*;

    logic [CRD_W-1:0]  x_min_reg, x_min_next;
    logic [CRD_W-1:0]  y_min_reg, y_min_next;
    logic [CRD_W-1:0]  band_low_reg, band_low_next;
    logic [CRD_W-1:0]  band_high_reg, band_high_next;
    logic [SIZE_W-1:0] grid_width_reg, grid_width_next;
    logic [SIZE_W-1:0] grid_height_reg, grid_height_next;

    cfg_t cfg;
    cmd_t q_in_data, q_out_data;
    logic q_in_valid, q_in_ready, q_out_valid, q_out_ready;
    logic init_done;

    assign cfg_ready = 1'b1;

    always_comb begin
        x_min_next       = x_min_reg;
        y_min_next       = y_min_reg;
        band_low_next    = band_low_reg;
        band_high_next   = band_high_reg;
        grid_width_next  = grid_width_reg;
        grid_height_next = grid_height_reg;
        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_ORIGIN_X:    x_min_next       = cfg_data;
                CFG_ORIGIN_Y:    y_min_next       = cfg_data;
                CFG_BAND_LOW:    band_low_next    = cfg_data;
                CFG_BAND_HIGH:   band_high_next   = cfg_data;
                CFG_GRID_WIDTH:  grid_width_next  = cfg_data[SIZE_W-1:0];
                CFG_GRID_HEIGHT: grid_height_next = cfg_data[SIZE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_min_reg       <= '0;
            y_min_reg       <= '0;
            band_low_reg    <= '0;
            band_high_reg   <= '0;
            grid_width_reg  <= SIZE_W'(1024);
            grid_height_reg <= SIZE_W'(1024);
        end else begin
            x_min_reg       <= x_min_next;
            y_min_reg       <= y_min_next;
            band_low_reg    <= band_low_next;
            band_high_reg   <= band_high_next;
            grid_width_reg  <= grid_width_next;
            grid_height_reg <= grid_height_next;
        end
    end

    always_comb begin
        cfg.x_min     = x_min_reg;
        cfg.y_min     = y_min_reg;
        cfg.band_low  = band_low_reg;
        cfg.band_high = band_high_reg;
        cfg.gw        = clamp_size(grid_width_reg, MAX_COLS);
        cfg.gh        = clamp_size(grid_height_reg, MAX_ROWS);
    end

    ofp_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .init_done(init_done),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .q_valid  (q_in_valid),
        .q_ready  (q_in_ready),
        .q_data   (q_in_data)
    );

    ofp_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_valid(q_in_valid),
        .push_ready(q_in_ready),
        .push_data (q_in_data),
        .pop_valid (q_out_valid),
        .pop_ready (q_out_ready),
        .pop_data  (q_out_data)
    );

    ofp_back #(
        .MAX_COLS(MAX_COLS),
        .MAX_ROWS(MAX_ROWS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_out_valid),
        .q_ready  (q_out_ready),
        .q_data   (q_out_data),
        .init_done(init_done),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule
`default_nettype wire
